@@ design/euc2w_pkg.sv @@
// ----------------------------------------------------------------------------
// euc2w_pkg
// Shared types and constants of the EUC-JP to wide code decoder.
// ----------------------------------------------------------------------------
package euc2w_pkg;

    localparam logic [7:0]  BYTE_SS2       = 8'h8E;
    localparam logic [7:0]  BYTE_SS3       = 8'h8F;
    localparam logic [7:0]  BYTE_HIGH_BIT  = 8'h80;
    localparam logic [15:0] CODE_KANA_BASE = 16'h0080;
    localparam logic [15:0] CODE_SS3_BASE  = 16'h8000;
    localparam logic [15:0] CODE_DBL_BASE  = 16'h8080;
    localparam logic [15:0] CODES_MAX      = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET    = 16'd256;

    typedef struct packed {
        logic [15:0] wide_code;
        logic        is_end;
        logic        terminator_fit;
    } t_result;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SS2  = 5'b00010,
        PH_SS3A = 5'b00100,
        PH_SS3B = 5'b01000,
        PH_DBL  = 5'b10000
    } t_phase;

endpackage

@@ design/euc2w_result_fifo.sv @@
// ----------------------------------------------------------------------------
// euc2w_result_fifo
// Small result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module euc2w_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  euc2w_pkg::t_push  i_push,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output euc2w_pkg::t_result o_result
);
    import euc2w_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_result         mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wr_ptr1;
    logic            pop;
    logic [CW-1:0]   push_cnt;

    assign wr_ptr1  = r_wr_ptr + PW'(1);
    assign pop      = o_valid && i_ready;
    assign push_cnt = CW'(i_push.valid0) + CW'(i_push.valid1);
    assign o_valid  = (r_count != '0);
    assign o_space  = (r_count <= CW'(DEPTH - 2));
    assign o_result = mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(push_cnt);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_count  = r_count + push_cnt - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            mem[wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count exceeds depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + push_cnt - CW'(pop)) <= CW'(DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid1 |-> i_push.valid0)
        else $error("second result pushed without first");

endmodule

@@ design/euc_to_wide_char_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// euc_to_wide_char_decoder_unit
// Decodes an EUC-JP byte stream into 16-bit wide codes with end records.
// ----------------------------------------------------------------------------
// The input channel carries one source byte per item, with tlast on the final
// byte of a buffer. The output channel carries one result per item: a decoded
// wide code, or an end record (tuser high) that reports whether the zero
// terminator fit within the configured capacity. The capacity register is
// written through i_out_limit_we and i_out_limit_wdata; the user must write it
// only while the block idles, which the block does not enforce. Each byte is
// decoded in the cycle it is accepted and its results enter a four-entry result
// queue, which offers them in order. One byte is accepted per cycle while the
// queue has space; a byte that yields two results, a code and an end record,
// takes two output items. s_axis_tready drops when the queue has fewer than two
// free entries, so a stalled receiver holds back the source once the queue holds
// more than two results. Reset clears state and queue and sets capacity to 256.
// ----------------------------------------------------------------------------
module euc_to_wide_char_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_limit_we,
    input  logic [15:0] i_out_limit_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] wide_code, [16] terminator_fit, rest zero
    output logic        m_axis_tuser    // is_end
);
    import euc2w_pkg::*;

    logic [15:0] r_out_limit;
    t_phase      r_phase, n_phase;
    logic [6:0]  r_held_high, n_held_high;
    logic [15:0] r_codes_written, n_codes_written;
    logic        r_stopped, n_stopped;

    logic        accept;
    logic        space;
    logic [7:0]  in_byte;
    logic        in_last;
    logic [6:0]  lo7;
    logic        have_code;
    logic [15:0] code;
    logic [15:0] cw_inc;
    logic [16:0] cw_plus1;
    t_push       push;
    t_result     out_res;

    assign in_byte       = s_axis_tdata;
    assign in_last       = s_axis_tlast;
    assign lo7           = in_byte[6:0];
    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;
    assign cw_plus1      = {1'b0, r_codes_written} + 17'd1;
    assign cw_inc        = r_codes_written + 16'((r_codes_written != CODES_MAX) ? 1 : 0);

    always_comb begin
        n_phase         = r_phase;
        n_held_high     = r_held_high;
        n_codes_written = r_codes_written;
        n_stopped       = r_stopped;
        have_code       = 1'b0;
        code            = '0;
        push            = '0;

        if (accept) begin
            if (r_stopped) begin
                if (in_last) begin
                    n_stopped = 1'b0;
                    n_codes_written = '0;
                end
            end else begin
                unique case (r_phase)
                    PH_SS2: begin
                        have_code = 1'b1;
                        code = CODE_KANA_BASE | {9'd0, lo7};
                    end
                    PH_SS3A: begin
                        if (in_last) begin
                            push.valid0 = 1'b1;
                            push.res0 = '{16'd0, 1'b1,
                                cw_plus1 < {1'b0, r_out_limit}};
                            n_phase = PH_IDLE;
                            n_held_high = '0;
                            n_codes_written = '0;
                        end else begin
                            n_held_high = lo7;
                            n_phase = PH_SS3B;
                        end
                    end
                    PH_SS3B: begin
                        have_code = 1'b1;
                        code = CODE_SS3_BASE | {1'b0, r_held_high, 1'b0, lo7};
                    end
                    PH_DBL: begin
                        have_code = 1'b1;
                        code = CODE_DBL_BASE | {1'b0, r_held_high, 1'b0, lo7};
                    end
                    default: begin
                        if (in_byte == 8'd0 || r_codes_written >= r_out_limit) begin
                            push.valid0 = 1'b1;
                            push.res0 = '{16'd0, 1'b1, r_codes_written < r_out_limit};
                            n_phase = PH_IDLE;
                            n_held_high = '0;
                            if (in_last) begin
                                n_codes_written = '0;
                            end else begin
                                n_stopped = 1'b1;
                            end
                        end else if (in_byte < BYTE_HIGH_BIT) begin
                            have_code = 1'b1;
                            code = {8'd0, in_byte};
                        end else if (in_last) begin
                            push.valid0 = 1'b1;
                            push.res0 = '{16'd0, 1'b1,
                                cw_plus1 < {1'b0, r_out_limit}};
                            n_phase = PH_IDLE;
                            n_held_high = '0;
                            n_codes_written = '0;
                        end else if (in_byte == BYTE_SS2) begin
                            n_phase = PH_SS2;
                        end else if (in_byte == BYTE_SS3) begin
                            n_phase = PH_SS3A;
                        end else begin
                            n_held_high = lo7;
                            n_phase = PH_DBL;
                        end
                    end
                endcase

                if (have_code) begin
                    push.valid0 = 1'b1;
                    push.res0 = '{code, 1'b0, 1'b0};
                    n_codes_written = cw_inc;
                    n_phase = PH_IDLE;
                    n_held_high = '0;
                    if (in_last) begin
                        push.valid1 = 1'b1;
                        push.res1 = '{16'd0, 1'b1, cw_inc < r_out_limit};
                        n_codes_written = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit     <= LIMIT_RESET;
            r_phase         <= PH_IDLE;
            r_held_high     <= '0;
            r_codes_written <= '0;
            r_stopped       <= 1'b0;
        end else begin
            if (i_out_limit_we) begin
                r_out_limit <= i_out_limit_wdata;
            end
            r_phase         <= n_phase;
            r_held_high     <= n_held_high;
            r_codes_written <= n_codes_written;
            r_stopped       <= n_stopped;
        end
    end

    euc2w_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.terminator_fit, out_res.wide_code};
    assign m_axis_tuser = out_res.is_end;

    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_phase == PH_IDLE))
        else $error("decoder stopped outside idle phase");

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_SS2 || r_phase == PH_SS3A)
            |-> (r_held_high == '0))
        else $error("held high byte not cleared");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_last) |=> (r_codes_written == '0 && !r_stopped
            && r_phase == PH_IDLE))
        else $error("decoder not rearmed after last byte");

    a_end_only_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid1 |-> (push.res1.is_end && !push.res0.is_end))
        else $error("second result is not an end record after a code");

endmodule
